/* src/utcl_pkg.sv */
// Shared types and calendar helpers for the UTC to local date/time converter.
package utcl_pkg;

    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned SECOND_W = 6;
    localparam int unsigned ZONE_W   = 5;
    localparam int unsigned TDATA_W  = 40;

    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [HOUR_W-1:0]  HOUR_MAX  = 5'd23;
    localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_LAST_DEC = 5'd31;

    // One date/time beat, last field (year) in the lowest bits
    typedef struct packed {
        logic [SECOND_W-1:0] second;
        logic [MINUTE_W-1:0] minute;
        logic [HOUR_W-1:0]   hour;
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
    } date_time_t;

    // Days in a month, given the leap flag of its year
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        len = 5'd31;
        if (m == MONTH_FEB) begin
            len = leap ? 5'd29 : 5'd28;
        end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP ||
                     m == MONTH_NOV) begin
            len = 5'd30;
        end
        return len;
    endfunction

endpackage

/* src/utcl_convert.sv */
// Combinational zone shift: input clamping, leap test and day/month/year carry.
module utcl_convert (
    input  utcl_pkg::date_time_t            utc,
    input  logic signed [utcl_pkg::ZONE_W-1:0] zone,
    output utcl_pkg::date_time_t            local_dt
);
    import utcl_pkg::*;

    logic [YEAR_W-1:0]  y;
    logic [MONTH_W-1:0] m;
    logic [DAY_W-1:0]   d;
    logic [HOUR_W-1:0]  h;
    logic [DAY_W-1:0]   len;
    logic [DAY_W-1:0]   prev_len;
    logic [26:0]        q_prod;
    logic [6:0]         cent;
    logic [YEAR_W-1:0]  cent_x100;
    logic               div100;
    logic               leap;
    logic signed [6:0]  hh;

    // Clamp the input fields into range
    always_comb begin
        y = (utc.year > YEAR_MAX) ? YEAR_MAX : utc.year;
        m = utc.month;
        if (m < MONTH_JAN) m = MONTH_JAN;
        if (m > MONTH_DEC) m = MONTH_DEC;
        h = (utc.hour > HOUR_MAX) ? HOUR_MAX : utc.hour;
    end

    // Leap test: century by reciprocal multiply, exact for years up to 9999
    assign q_prod    = {13'd0, y} * 27'd5243;
    assign cent      = q_prod[25:19];
    assign cent_x100 = ({7'd0, cent} << 6) + ({7'd0, cent} << 5) + ({7'd0, cent} << 2);
    assign div100    = (cent_x100 == y);
    assign leap      = div100 ? (cent[1:0] == 2'd0) : (y[1:0] == 2'd0);

    assign len      = month_len(m, leap);
    assign prev_len = month_len(m - MONTH_JAN, leap);

    always_comb begin
        d = utc.day;
        if (d < DAY_FIRST) d = DAY_FIRST;
        if (d > len) d = len;
    end

    assign hh = $signed({2'b00, h}) + 7'(zone);

    // Apply the shift and carry into the calendar
    always_comb begin
        local_dt.year   = y;
        local_dt.month  = m;
        local_dt.day    = d;
        local_dt.hour   = hh[HOUR_W-1:0];
        local_dt.minute = utc.minute;
        local_dt.second = utc.second;
        if (hh >= 7'sd24) begin
            local_dt.hour = 5'(hh - 7'sd24);
            if (d < len) begin
                local_dt.day = d + 5'd1;
            end else if (m < MONTH_DEC) begin
                local_dt.day   = DAY_FIRST;
                local_dt.month = m + 4'd1;
            end else if (y < YEAR_MAX) begin
                local_dt.day   = DAY_FIRST;
                local_dt.month = MONTH_JAN;
                local_dt.year  = y + 14'd1;
            end else begin
                // saturate at the last representable hour
                local_dt.day   = DAY_LAST_DEC;
                local_dt.month = MONTH_DEC;
                local_dt.hour  = HOUR_MAX;
            end
        end else if (hh < 7'sd0) begin
            local_dt.hour = 5'(hh + 7'sd24);
            if (d > DAY_FIRST) begin
                local_dt.day = d - 5'd1;
            end else if (m > MONTH_JAN) begin
                local_dt.month = m - 4'd1;
                local_dt.day   = prev_len;
            end else if (y > 14'd0) begin
                local_dt.year  = y - 14'd1;
                local_dt.month = MONTH_DEC;
                local_dt.day   = DAY_LAST_DEC;
            end else begin
                // saturate at the first representable hour
                local_dt.day   = DAY_FIRST;
                local_dt.month = MONTH_JAN;
                local_dt.hour  = 5'd0;
            end
        end
    end

endmodule

/* src/utc_to_local_date_time.sv */
// Top level: input register, zone shift logic, result register, offset register.
//
//  channel  | dir | fields (tdata, low bit up)
//  s_axis   | in  | year[13:0] month[17:14] day[22:18] hour[27:23] minute[33:28] second[39:34]
//  m_axis   | out | same layout, local date and time
//  cfg      | in  | cfg_wr_data = signed zone offset in hours
//
// One beat per cycle sustained while m_tready is high; data passes the input register, then the result register.
// The conversion itself is a single pass of logic between those two registers.
// aresetn (synchronous, active low) empties both stages and zeroes the offset.
// A stall on m_tready holds the result; the input stage still fills if it is empty.
module utc_to_local_date_time (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // year, month, day, hour, minute, second
    input  logic [utcl_pkg::TDATA_W-1:0]      s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // year, month, day, hour, minute, second
    output logic [utcl_pkg::TDATA_W-1:0]      m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [utcl_pkg::ZONE_W-1:0]       cfg_wr_data
);
    import utcl_pkg::*;

    logic              in_valid_reg;
    date_time_t        in_data_reg;
    logic              out_valid_reg;
    date_time_t        out_data_reg;
    logic signed [ZONE_W-1:0] zone_reg;
    logic              in_ready;
    logic              out_ready;
    date_time_t        conv_dt;

    assign out_ready = !out_valid_reg || m_tready;
    assign in_ready  = !in_valid_reg || out_ready;
    assign s_tready  = in_ready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    utcl_convert u_convert (
        .utc      (in_data_reg),
        .zone     (zone_reg),
        .local_dt (conv_dt)
    );

    // Offset register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zone_reg <= '0;
        end else if (cfg_wr_en) begin
            zone_reg <= $signed(cfg_wr_data);
        end
    end

    // Two-stage pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_ready) in_valid_reg <= s_tvalid;
            if (out_ready) out_valid_reg <= in_valid_reg;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (in_ready && s_tvalid) in_data_reg <= s_tdata;
        if (out_ready && in_valid_reg) out_data_reg <= conv_dt;
    end

`ifndef ASSERT_OFF
    a_hour_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_data_reg.hour <= HOUR_MAX))
        else $error("result hour out of range");

    a_month_day: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_data_reg.month >= MONTH_JAN && out_data_reg.month <= MONTH_DEC &&
                      out_data_reg.day >= DAY_FIRST))
        else $error("result month or day out of range");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !in_valid_reg)
        else $error("pipeline not empty after reset");

    a_pass_minute: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_ready) |=> (out_data_reg.minute == $past(in_data_reg.minute)))
        else $error("minute not passed through");
`endif

endmodule
